// ===== rtl/rhcm_pkg.sv =====
// Shared constants, opcodes, status codes and hash mixing constants for the coordinate map.
package rhcm_pkg;

   localparam int SLOTS_DEFAULT = 1024;
   localparam int ID_W = 10;
   localparam int STATUS_W = 2;
   localparam int OP_W = 2;
   localparam int KEY_W = 64;
   localparam int HALF_W = 32;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_ID = 2'd3;

   localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

endpackage

// ===== rtl/robin_hood_coord_map.sv =====
// Top level of the Robin Hood coordinate map.
// A request carries op, pos_x and pos_y on the req_ channel (valid and ready).
// Op 0 looks the key up, op 1 inserts it with the lowest free id, op 2 removes
// it; op 3 acts as a lookup. Each request yields one response on the rsp_
// channel with rsp_entry_id and rsp_status (0 ok, 1 not found, 2 already
// present, 3 no free id).
// One request is in work at a time. The key is first hashed by a splitmix64
// finalizer over one shared 16-bit digit multiplier. The probe then visits
// slots in the slot memory, each through its registered read; insert adds a
// scan of the id bitmap up to the lowest free id and a placement walk over
// the occupied slots passed; remove adds a backward shift walk over the moved
// entries. A new request can be taken once the previous result has reached
// the output register.
// After reset a clearing pass writes the slot valid memory and the id bitmap;
// req_ready stays low during it.
// A finished response waits in an output register; while rsp_ready is low the
// next request is still taken and worked on, and its result waits for the
// output register to empty.
module robin_hood_coord_map
   import rhcm_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [HALF_W-1:0]   req_pos_x,
   input  logic signed [HALF_W-1:0]   req_pos_y,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ID_W-1:0]            rsp_entry_id,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int AW = $clog2(SLOTS);

   logic              busy_ff, busy_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              hdone;
   logic [63:0]       hash;
   logic              tdone;
   logic [ID_W-1:0]   tid;
   logic [STATUS_W-1:0] tst;
   logic              clearing;
   logic              hold_ff, hold_in;
   logic [ID_W-1:0]   hid_ff, hid_in;
   logic [STATUS_W-1:0] hst_ff, hst_in;
   logic              ov_ff, ov_in;
   logic [ID_W-1:0]   oid_ff, oid_in;
   logic [STATUS_W-1:0] ost_ff, ost_in;
   logic              accept;

   assign req_ready = !busy_ff && !clearing && !hold_ff;
   assign accept = req_valid && req_ready;

   rhcm_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   ({req_pos_x, req_pos_y}),
      .done  (hdone),
      .hash  (hash)
   );

   rhcm_table #(.SLOTS(SLOTS)) u_table (
      .clock      (clock),
      .reset      (reset),
      .start      (hdone),
      .op         (op_ff),
      .key        (key_ff),
      .home       (hash[AW-1:0]),
      .done       (tdone),
      .res_id     (tid),
      .res_status (tst),
      .clearing   (clearing)
   );

   always_comb begin
      busy_in = busy_ff;
      op_in = op_ff;
      key_in = key_ff;
      hold_in = hold_ff;
      hid_in = hid_ff;
      hst_in = hst_ff;
      ov_in = ov_ff;
      oid_in = oid_ff;
      ost_in = ost_ff;
      if (accept) begin
         busy_in = 1'b1;
         op_in = req_op;
         key_in = {req_pos_x, req_pos_y};
      end
      if (ov_ff && rsp_ready) begin
         ov_in = 1'b0;
      end
      if (tdone) begin
         busy_in = 1'b0;
         hold_in = 1'b1;
         hid_in = tid;
         hst_in = tst;
      end
      if (hold_ff && !ov_in) begin
         hold_in = 1'b0;
         ov_in = 1'b1;
         oid_in = hid_ff;
         ost_in = hst_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         hold_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         hold_ff <= hold_in;
         ov_ff <= ov_in;
      end
      op_ff <= op_in;
      key_ff <= key_in;
      hid_ff <= hid_in;
      hst_ff <= hst_in;
      oid_ff <= oid_in;
      ost_ff <= ost_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_entry_id = oid_ff;
   assign rsp_status = ost_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready)
      else $error("request taken while one is in work");
   a_done_only_busy: assert property (@(posedge clock) disable iff (reset)
      tdone |-> busy_ff)
      else $error("table finished with no request in work");
   a_hold_no_done: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> !tdone)
      else $error("result overwrote a held result");
`endif

endmodule

// ===== rtl/rhcm_mul64.sv =====
// Multi-cycle 64 by 64 bit multiplier, low 64 bits of the product, 16-bit digits.
module rhcm_mul64
   import rhcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [79:0] part;

   // Each step multiplies a by one 16-bit digit of b and shifts a up one digit.
   assign part = a_ff * {64'd0, b_ff[15:0]};

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = op_a;
         b_in = op_b;
         acc_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + part[63:0];
         a_in = {a_ff[47:0], 16'd0};
         b_in = {16'd0, b_ff[63:16]};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/rhcm_hash.sv =====
// Splitmix64 finalizer computed over several cycles with one shared multiplier.
module rhcm_hash
   import rhcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   output logic        done,
   output logic [63:0] hash
);

   logic        mstart;
   logic [63:0] ma, mb;
   logic        mdone;
   logic [63:0] mprod;
   logic        second_ff, second_in;
   logic        done_ff, done_in;
   logic [63:0] hash_ff, hash_in;

   rhcm_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mstart),
      .op_a    (ma),
      .op_b    (mb),
      .done    (mdone),
      .product (mprod)
   );

   always_comb begin
      mstart = 1'b0;
      ma = key ^ (key >> 30);
      mb = MIX_C1;
      second_in = second_ff;
      done_in = 1'b0;
      hash_in = hash_ff;
      if (start) begin
         mstart = 1'b1;
         second_in = 1'b0;
      end else if (mdone && !second_ff) begin
         mstart = 1'b1;
         ma = mprod ^ (mprod >> 27);
         mb = MIX_C2;
         second_in = 1'b1;
      end else if (mdone && second_ff) begin
         hash_in = mprod ^ (mprod >> 31);
         done_in = 1'b1;
         second_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
         done_ff <= done_in;
      end
      hash_ff <= hash_in;
   end

   assign done = done_ff;
   assign hash = hash_ff;

endmodule

// ===== rtl/rhcm_idalloc.sv =====
// Id allocation bitmap in a memory with a scan for the lowest free id.
module rhcm_idalloc
   import rhcm_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int AW = $clog2(SLOTS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          scan_start,
   output logic          scan_done,
   output logic          scan_found,
   output logic [AW-1:0] scan_id,
   input  logic          set_en,
   input  logic          clr_en,
   input  logic [AW-1:0] wr_id,
   output logic          clearing
);

   logic          bits_mem [SLOTS];
   logic          rd_ff;
   logic [AW-1:0] raddr;
   logic [AW:0]   ptr_ff, ptr_in;
   logic          scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pid_ff, pid_in;
   logic          done_ff, done_in;
   logic          found_ff, found_in;
   logic [AW-1:0] fid_ff, fid_in;
   logic [AW:0]   clr_ff, clr_in;
   logic          mwe;
   logic [AW-1:0] maddr;
   logic          mdata;

   assign clearing = !clr_ff[AW];
   assign raddr = ptr_ff[AW-1:0];

   // After reset a pass writes every bit, with id 0 marked in use.
   always_comb begin
      mwe = 1'b0;
      maddr = wr_id;
      mdata = set_en;
      clr_in = clr_ff;
      if (clearing) begin
         mwe = 1'b1;
         maddr = clr_ff[AW-1:0];
         mdata = (clr_ff == '0);
         clr_in = clr_ff + 1'b1;
      end else if (set_en || clr_en) begin
         mwe = 1'b1;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      scan_in = scan_ff;
      pend_in = 1'b0;
      pid_in = raddr;
      done_in = 1'b0;
      found_in = found_ff;
      fid_in = fid_ff;
      if (scan_start) begin
         ptr_in = {{AW{1'b0}}, 1'b1};
         scan_in = 1'b1;
      end else if (scan_ff) begin
         if (pend_ff && !rd_ff) begin
            scan_in = 1'b0;
            done_in = 1'b1;
            found_in = 1'b1;
            fid_in = pid_ff;
         end else if (ptr_ff[AW]) begin
            if (!pend_ff) begin
               scan_in = 1'b0;
               done_in = 1'b1;
               found_in = 1'b0;
            end
         end else begin
            pend_in = 1'b1;
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mwe) begin
         bits_mem[maddr] <= mdata;
      end
      rd_ff <= bits_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         scan_ff <= 1'b0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
         ptr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         scan_ff <= scan_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
         ptr_ff <= ptr_in;
      end
      pid_ff <= pid_in;
      found_ff <= found_in;
      fid_ff <= fid_in;
   end

   assign scan_done = done_ff;
   assign scan_found = found_ff;
   assign scan_id = fid_ff;

endmodule

// ===== rtl/rhcm_table.sv =====
// Slot memory with probe, Robin Hood placement and backward shift removal.
module rhcm_table
   import rhcm_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int AW = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OP_W-1:0]   op,
   input  logic [KEY_W-1:0]  key,
   input  logic [AW-1:0]     home,
   output logic              done,
   output logic [ID_W-1:0]   res_id,
   output logic [STATUS_W-1:0] res_status,
   output logic              clearing
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_FIND  = 8'b00000010,
      S_SCAN  = 8'b00000100,
      S_PLACE = 8'b00001000,
      S_SHIFT = 8'b00010000,
      S_DONE  = 8'b00100000,
      S_CLEAR = 8'b01000000,
      S_WAIT  = 8'b10000000
   } state_type;

   localparam int EW = KEY_W + AW + AW;

   logic [EW-1:0] slot_mem [SLOTS];
   logic [EW-1:0] rd_ff;
   logic          vld_mem [SLOTS];
   logic          vrd_ff;
   logic [AW-1:0] raddr;
   logic          wen;
   logic [AW-1:0] waddr;
   logic [EW-1:0] wdata;
   logic          vwen;
   logic          vdata;

   state_type     st_ff, st_in;
   logic [AW:0]   clr_ff, clr_in;
   logic [AW-1:0] p_ff, p_in;
   logic [AW-1:0] d_ff, d_in;
   logic          rv_ff, rv_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [KEY_W-1:0] k_ff, k_in;
   logic [AW-1:0] h_ff, h_in;
   logic [AW-1:0] i_ff, i_in;
   logic [ID_W-1:0] rid_ff, rid_in;
   logic [STATUS_W-1:0] rst_ff, rst_in;

   logic          sc_start, sc_done, sc_found, id_set, id_clr, id_clearing;
   logic [AW-1:0] sc_id, id_wr;

   logic [KEY_W-1:0] r_key;
   logic [AW-1:0] r_home, r_id, r_pd;
   logic          r_used;

   rhcm_idalloc #(.SLOTS(SLOTS)) u_ids (
      .clock      (clock),
      .reset      (reset),
      .scan_start (sc_start),
      .scan_done  (sc_done),
      .scan_found (sc_found),
      .scan_id    (sc_id),
      .set_en     (id_set),
      .clr_en     (id_clr),
      .wr_id      (id_wr),
      .clearing   (id_clearing)
   );

   assign {r_key, r_home, r_id} = rd_ff;
   assign r_used = vrd_ff && (r_id != '0);
   assign r_pd = p_ff - r_home;
   assign raddr = p_in;
   assign clearing = (st_ff == S_CLEAR) || id_clearing;

   // Each probe step: the slot at p_ff was read last cycle; rv_ff marks the data good.
   always_comb begin
      st_in = st_ff;
      clr_in = clr_ff;
      p_in = p_ff;
      d_in = d_ff;
      rv_in = 1'b0;
      op_in = op_ff;
      k_in = k_ff;
      h_in = h_ff;
      i_in = i_ff;
      rid_in = rid_ff;
      rst_in = rst_ff;
      wen = 1'b0;
      waddr = p_ff;
      wdata = {k_ff, h_ff, i_ff};
      vwen = 1'b0;
      vdata = 1'b1;
      sc_start = 1'b0;
      id_set = 1'b0;
      id_clr = 1'b0;
      id_wr = i_ff;
      case (st_ff)
         S_CLEAR: begin
            vwen = 1'b1;
            vdata = 1'b0;
            waddr = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(SLOTS - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in = op;
               k_in = key;
               h_in = home;
               p_in = home;
               d_in = '0;
               rv_in = 1'b1;
               st_in = S_FIND;
            end
         end
         S_FIND: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
            end else if (!r_used || d_ff > r_pd || d_ff == AW'(SLOTS - 1)
                         && r_key != k_ff) begin
               if (op_ff == OP_INSERT) begin
                  sc_start = 1'b1;
                  st_in = S_SCAN;
               end else begin
                  rid_in = '0;
                  rst_in = ST_NOT_FOUND;
                  st_in = S_DONE;
               end
            end else if (r_key == k_ff) begin
               rid_in = ID_W'(r_id);
               if (op_ff == OP_INSERT) begin
                  rst_in = ST_DUPLICATE;
                  st_in = S_DONE;
               end else if (op_ff == OP_REMOVE) begin
                  rst_in = ST_OK;
                  id_clr = 1'b1;
                  id_wr = r_id;
                  p_in = p_ff + 1'b1;
                  rv_in = 1'b1;
                  st_in = S_SHIFT;
               end else begin
                  rst_in = ST_OK;
                  st_in = S_DONE;
               end
            end else begin
               p_in = p_ff + 1'b1;
               d_in = d_ff + 1'b1;
               rv_in = 1'b1;
            end
         end
         S_SCAN: begin
            if (sc_done) begin
               if (sc_found) begin
                  id_set = 1'b1;
                  id_wr = sc_id;
                  i_in = sc_id;
                  rid_in = ID_W'(sc_id);
                  rst_in = ST_OK;
                  p_in = h_ff;
                  d_in = '0;
                  rv_in = 1'b1;
                  st_in = S_PLACE;
               end else begin
                  rid_in = '0;
                  rst_in = ST_NO_ID;
                  st_in = S_DONE;
               end
            end
         end
         S_PLACE: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
            end else if (!r_used) begin
               wen = 1'b1;
               vwen = 1'b1;
               st_in = S_DONE;
            end else begin
               p_in = p_ff + 1'b1;
               d_in = d_ff + 1'b1;
               rv_in = 1'b1;
               st_in = S_WAIT;
               if (r_pd < d_ff) begin
                  wen = 1'b1;
                  vwen = 1'b1;
                  k_in = r_key;
                  h_in = r_home;
                  i_in = r_id;
                  d_in = r_pd + 1'b1;
               end
            end
         end
         S_WAIT: begin
            // The slot just written is never the next one read; this state adds a bubble before placement resumes.
            st_in = S_PLACE;
         end
         S_SHIFT: begin
            // p_ff is the successor q of the hole at p_ff - 1.
            if (!rv_ff) begin
               rv_in = 1'b1;
            end else if (!r_used || r_pd == '0) begin
               waddr = p_ff - 1'b1;
               wen = 1'b1;
               wdata = '0;
               vwen = 1'b1;
               st_in = S_DONE;
            end else begin
               waddr = p_ff - 1'b1;
               wen = 1'b1;
               wdata = rd_ff;
               vwen = 1'b1;
               p_in = p_ff + 1'b1;
               rv_in = 1'b1;
            end
         end
         S_DONE: begin
            st_in = S_IDLE;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         slot_mem[waddr] <= wdata;
      end
      if (vwen) begin
         vld_mem[waddr] <= vdata;
      end
      rd_ff <= slot_mem[raddr];
      vrd_ff <= vld_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
      end
      p_ff <= p_in;
      d_ff <= d_in;
      op_ff <= op_in;
      k_ff <= k_in;
      h_ff <= h_in;
      i_ff <= i_in;
      rid_ff <= rid_in;
      rst_ff <= rst_in;
   end

   assign done = (st_ff == S_DONE);
   assign res_id = rid_ff;
   assign res_status = rst_ff;

`ifndef NO_ASSERTIONS
   a_wait_follows_place: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_WAIT |=> st_ff == S_PLACE)
      else $error("wait bubble did not return to placement");
   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DONE |=> st_ff == S_IDLE)
      else $error("done held more than one cycle");
   a_no_id_on_miss: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DONE && rst_ff == ST_NOT_FOUND |-> rid_ff == '0)
      else $error("miss reported a nonzero id");
`endif

endmodule
